FILE: sv/yl_pkg.sv
// ----------------------------------------------------------------------------
// yl_pkg
// Shared constants, types and the spline coefficient ROM contents for the
// YUV to Lab converter.
// ----------------------------------------------------------------------------
package yl_pkg;

  // Spline table geometry (entries are a power of two, index wraps)
  localparam int TABLE_BITS    = 10;
  localparam int TABLE_ENTRIES = 1 << TABLE_BITS;

  // Register file
  localparam int NUM_REGS   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_FROM_U = 3'd0,
    REG_X_FROM_V = 3'd1,
    REG_Z_FROM_U = 3'd2,
    REG_Z_FROM_V = 3'd3,
    REG_A_GAIN   = 3'd4,
    REG_B_GAIN   = 3'd5
  } reg_idx_e;

  // Datapath widths
  localparam int PY_W       = TABLE_BITS + 16;  // luma position, unsigned Q.16
  localparam int POS_W      = 35;               // signed table position, Q.16
  localparam int COEF_W     = 32;
  localparam int NUM_STAGES = 11;

  typedef logic [4*COEF_W-1:0] rom_word_t;
  typedef rom_word_t rom_array_t [TABLE_ENTRIES];

  // Load enables of the spline evaluator stages
  typedef struct packed {
    logic ld_rom;
    logic ld_mul1;
    logic ld_mul2;
    logic ld_mul3;
    logic ld_sum;
  } spl_en_t;

  // Load enables of the Lab output stages
  typedef struct packed {
    logic ld_diff;
    logic ld_prod;
    logic ld_scale;
    logic ld_out;
  } post_en_t;

  localparam longint Q30_ONE = longint'(1) << 30;

  // round(p / 2^16), ties up, for a 48-bit product
  function automatic logic signed [32:0] rnd_q16(logic signed [47:0] p);
    logic signed [48:0] t;
    t = 49'(p) + 49'sd32768;
    return 33'(t >>> 16);
  endfunction

  // ---- elaboration-time table build ----

  // unsigned quotient by shift and subtract
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], n[k]};
      if (r >= d) begin
        r    = r - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > longint'(32'h7FFF_FFFF)) return longint'(32'h7FFF_FFFF);
    if (v < -(longint'(1) << 31))    return -(longint'(1) << 31);
    return v;
  endfunction

  function automatic longint sar_rnd30(longint v);
    return (v + (longint'(1) << 29)) >>> 30;
  endfunction

  // round(n / 3), ties up, floor semantics for negative n
  function automatic longint rnd3(longint n);
    longint num;
    longint q;
    num = 2 * n + 3;
    if (num >= 0) q = longint'(udiv(64'(num), 64'd6));
    else          q = -longint'(udiv(64'(5 - num), 64'd6));
    return q;
  endfunction

  // Lab f at x = 2*i/TABLE_ENTRIES, Q2.30
  function automatic longint curve_knot(longint i);
    longint unsigned full;
    longint unsigned tq;
    longint unsigned tr;
    longint unsigned target;
    longint unsigned root;
    longint unsigned c;
    logic [127:0]    cube;
    longint          n;
    longint          lin;
    longint          off;
    if (2 * i * 24389 > 216 * TABLE_ENTRIES) begin
      // floor cube root of x in Q.60, bit by bit
      full   = 64'd1 << 61;
      tq     = full >> TABLE_BITS;
      tr     = full & 64'(TABLE_ENTRIES - 1);
      target = tq * longint'(i) + ((tr * longint'(i)) >> TABLE_BITS);
      root   = 0;
      for (int b = 21; b >= 0; b--) begin
        c    = root | (64'd1 << b);
        cube = 128'(c) * 128'(c) * 128'(c);
        if (cube <= 128'(target)) root = c;
      end
      return longint'(root << 10);
    end
    n   = (i * 1682) << 30;
    lin = longint'(udiv(64'(2 * n + 108 * TABLE_ENTRIES), 64'(216 * TABLE_ENTRIES)));
    off = longint'(udiv(64'(2 * (longint'(16) << 30) + 116), 64'd232));
    return lin + off;
  endfunction

  // Natural cubic spline through the knots, one row per segment
  function automatic rom_array_t build_curve();
    rom_array_t rom;
    longint     kv [TABLE_ENTRIES+1];
    longint     el [TABLE_ENTRIES];
    longint     em [TABLE_ENTRIES];
    longint     t;
    longint     den;
    longint     l;
    longint     c;
    longint     b;
    longint     d;
    longint     cn;
    for (int i = 0; i <= TABLE_ENTRIES; i++) kv[i] = curve_knot(longint'(i));
    el[0] = 0;
    em[0] = 0;
    cn    = 0;
    // forward elimination
    for (int i = 1; i < TABLE_ENTRIES; i++) begin
      t     = 3 * (kv[i+1] - 2 * kv[i] + kv[i-1]);
      den   = 4 * Q30_ONE - el[i-1];
      l     = longint'(udiv(64'(2 * Q30_ONE * Q30_ONE + den), 64'(2 * den)));
      el[i] = l;
      em[i] = sar_rnd30((t - em[i-1]) * l);
    end
    // back substitution
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      c      = em[i] - sar_rnd30(el[i] * cn);
      b      = kv[i+1] - kv[i] - rnd3(cn + 2 * c);
      d      = rnd3(cn - c);
      rom[i] = {32'(clamp32(d)), 32'(clamp32(c)), 32'(clamp32(b)),
                32'(clamp32(kv[i]))};
      cn     = c;
    end
    return rom;
  endfunction

  localparam rom_array_t CURVE_ROM = build_curve();

endpackage

FILE: sv/yl_if.sv
// ----------------------------------------------------------------------------
// yl_if
// Valid/ready channels of the converter: pixel in, Lab out, register write.
// ----------------------------------------------------------------------------
interface yl_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] luma;
  logic [15:0] chroma_u;
  logic [15:0] chroma_v;
  logic        end_of_run;
  modport source (output valid, luma, chroma_u, chroma_v, end_of_run, input ready);
  modport sink   (input valid, luma, chroma_u, chroma_v, end_of_run, output ready);
endinterface

interface yl_lab_if;
  logic        valid;
  logic        ready;
  logic [15:0] lightness;
  logic [15:0] a_channel;
  logic [15:0] b_channel;
  logic        end_of_run_out;
  modport source (output valid, lightness, a_channel, b_channel, end_of_run_out,
                  input ready);
  modport sink   (input valid, lightness, a_channel, b_channel, end_of_run_out,
                  output ready);
endinterface

interface yl_cfg_if import yl_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/yl_curve_rom.sv
// ----------------------------------------------------------------------------
// yl_curve_rom
// Spline coefficient ROM with registered read, one row per segment.
// ----------------------------------------------------------------------------
module yl_curve_rom import yl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [TABLE_BITS-1:0] addr_i,
  output rom_word_t             data_o
);

  rom_word_t data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) data_q <= CURVE_ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

FILE: sv/yl_spline_eval.sv
// ----------------------------------------------------------------------------
// yl_spline_eval
// One channel of the f curve: ROM lookup then three Horner steps, each
// multiply registered, then the final add and clamp.
// ----------------------------------------------------------------------------
module yl_spline_eval import yl_pkg::*; (
  input  logic                    clk_i,
  input  spl_en_t                 en_i,
  input  logic [TABLE_BITS-1:0]   idx_i,
  input  logic [15:0]             frac_i,
  output logic signed [COEF_W-1:0] f_o
);

  rom_word_t               row;
  logic        [15:0]      frac3_q;
  logic signed [31:0]      e0, e1, e2, e3;

  // coefficient lookup
  yl_curve_rom u_rom (
    .clk_i   (clk_i),
    .rd_en_i (en_i.ld_rom),
    .addr_i  (idx_i),
    .data_o  (row)
  );

  always_ff @(posedge clk_i) begin
    if (en_i.ld_rom) frac3_q <= frac_i;
  end

  assign e0 = $signed(row[31:0]);
  assign e1 = $signed(row[63:32]);
  assign e2 = $signed(row[95:64]);
  assign e3 = $signed(row[127:96]);

  // step 1: cubic term times fraction
  logic signed [16:0] fr3;
  logic signed [48:0] m1;
  logic signed [47:0] p1_q;
  logic signed [31:0] c2_4_q, c1_4_q, c0_4_q;
  logic        [15:0] frac4_q;

  assign fr3 = $signed({1'b0, frac3_q});
  assign m1  = e3 * fr3;

  always_ff @(posedge clk_i) begin
    if (en_i.ld_mul1) begin
      p1_q    <= 48'(m1);
      c2_4_q  <= e2;
      c1_4_q  <= e1;
      c0_4_q  <= e0;
      frac4_q <= frac3_q;
    end
  end

  // step 2
  logic signed [16:0] fr4;
  logic signed [48:0] r1;
  logic signed [32:0] a1;
  logic signed [49:0] m2;
  logic signed [48:0] p2_q;
  logic signed [31:0] c1_5_q, c0_5_q;
  logic        [15:0] frac5_q;

  assign fr4 = $signed({1'b0, frac4_q});
  assign r1  = 49'(p1_q) + 49'sd32768;
  assign a1  = 33'(r1 >>> 16) + 33'(c2_4_q);
  assign m2  = a1 * fr4;

  always_ff @(posedge clk_i) begin
    if (en_i.ld_mul2) begin
      p2_q    <= 49'(m2);
      c1_5_q  <= c1_4_q;
      c0_5_q  <= c0_4_q;
      frac5_q <= frac4_q;
    end
  end

  // step 3
  logic signed [16:0] fr5;
  logic signed [49:0] r2;
  logic signed [33:0] a2;
  logic signed [50:0] m3;
  logic signed [49:0] p3_q;
  logic signed [31:0] c0_6_q;

  assign fr5 = $signed({1'b0, frac5_q});
  assign r2  = 50'(p2_q) + 50'sd32768;
  assign a2  = 34'(r2 >>> 16) + 34'(c1_5_q);
  assign m3  = a2 * fr5;

  always_ff @(posedge clk_i) begin
    if (en_i.ld_mul3) begin
      p3_q   <= 50'(m3);
      c0_6_q <= c0_5_q;
    end
  end

  // final add and clamp to 32 bits
  logic signed [50:0]       r3;
  logic signed [34:0]       a3;
  logic signed [COEF_W-1:0] f_d, f_q;

  assign r3 = 51'(p3_q) + 51'sd32768;
  assign a3 = 35'(r3 >>> 16) + 35'(c0_6_q);

  always_comb begin
    if (a3 > 35'sd2147483647)       f_d = 32'sh7FFF_FFFF;
    else if (a3 < -35'sd2147483648) f_d = 32'sh8000_0000;
    else                            f_d = a3[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_sum) f_q <= f_d;
  end

  assign f_o = f_q;

endmodule

FILE: sv/yl_lab_math.sv
// ----------------------------------------------------------------------------
// yl_lab_math
// L, a and b from fx, fy, fz: scale, gain, round and saturate.
// ----------------------------------------------------------------------------
module yl_lab_math import yl_pkg::*; (
  input  logic                     clk_i,
  input  post_en_t                 en_i,
  input  logic signed [COEF_W-1:0] fx_i,
  input  logic signed [COEF_W-1:0] fy_i,
  input  logic signed [COEF_W-1:0] fz_i,
  input  logic signed [31:0]       a_gain_i,
  input  logic signed [31:0]       b_gain_i,
  output logic [15:0]              lightness_o,
  output logic [15:0]              a_channel_o,
  output logic [15:0]              b_channel_o
);

  // clamp a 33-bit difference to 32 bits
  function automatic logic signed [31:0] clip32(logic signed [32:0] v);
    if (v > 33'sd2147483647)       return 32'sh7FFF_FFFF;
    if (v < -33'sd2147483648)      return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // round(p / 2^30) plus 32768, then saturate to 0..65535
  function automatic logic [15:0] out16(logic signed [63:0] p);
    logic signed [64:0] t;
    logic signed [34:0] s;
    t = 65'(p) + (65'sd1 <<< 45) + (65'sd1 <<< 29);
    s = 35'(t >>> 30);
    if (s < 35'sd0)     return 16'd0;
    if (s > 35'sd65535) return 16'hFFFF;
    return s[15:0];
  endfunction

  // stage A: 116*fy - 16, differences
  logic signed [39:0] z_d, z_q;
  logic signed [31:0] da_q, db_q;

  assign z_d = 40'(fy_i) * 40'sd116 - (40'sd1 <<< 34);

  always_ff @(posedge clk_i) begin
    if (en_i.ld_diff) begin
      z_q  <= z_d;
      da_q <= clip32(33'(fx_i) - 33'(fy_i));
      db_q <= clip32(33'(fy_i) - 33'(fz_i));
    end
  end

  // stage B: times 65535, rounded to units of 1/100; gain products
  logic signed [57:0] w;
  logic signed [57:0] wr;
  logic signed [27:0] u_q;
  logic signed [63:0] pa_q, pb_q;

  assign w  = (58'(z_q) <<< 16) - 58'(z_q);
  assign wr = w + (58'sd50 <<< 30);

  always_ff @(posedge clk_i) begin
    if (en_i.ld_prod) begin
      u_q  <= 28'(wr >>> 30);
      pa_q <= da_q * a_gain_i;
      pb_q <= db_q * b_gain_i;
    end
  end

  // stage C: divide by 100 as (u/4)/25 by reciprocal multiply
  localparam logic [21:0] RECIP_25 = 22'd2684355;   // ceil(2^26 / 25)
  logic        neg_q, big_q;
  logic [42:0] qm_q;
  logic [15:0] av_q, bv_q;

  always_ff @(posedge clk_i) begin
    if (en_i.ld_scale) begin
      neg_q <= u_q[27];
      big_q <= !u_q[27] && (u_q >= 28'sd6553600);
      qm_q  <= u_q[22:2] * RECIP_25;
      av_q  <= out16(pa_q);
      bv_q  <= out16(pb_q);
    end
  end

  // stage D: output register
  logic [15:0] l_q, a_q, b_q;

  always_ff @(posedge clk_i) begin
    if (en_i.ld_out) begin
      if (neg_q)      l_q <= 16'd0;
      else if (big_q) l_q <= 16'hFFFF;
      else            l_q <= qm_q[41:26];
      a_q <= av_q;
      b_q <= bv_q;
    end
  end

  assign lightness_o = l_q;
  assign a_channel_o = a_q;
  assign b_channel_o = b_q;

endmodule

FILE: sv/yuv_to_lab_spline_converter.sv
// ----------------------------------------------------------------------------
// yuv_to_lab_spline_converter
// YUV pixel stream to CIELAB with a spline-evaluated f curve.
// ----------------------------------------------------------------------------
// One pixel per clock while the output is ready. The block is an 11-stage
// pipeline: chroma weighting (one 17x32 multiply per term), position sum,
// coefficient ROM read, three Horner multiply stages per channel, the final
// add and clamp, then the L/a/b scaling stages and an output register. Each
// stage holds only while its own result is stuck, so empty slots close up and
// the input keeps taking beats while a finished pixel waits at the output.
// The spline ROM is computed when the design is elaborated and is held in
// three copies, one per channel, so X, Y and Z are looked up in the same
// cycle. Register writes take effect at once; write them only while no pixel
// is in flight.
// ----------------------------------------------------------------------------
module yuv_to_lab_spline_converter import yl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  yl_cfg_if.sink   cfg_i,
  yl_pix_if.sink   pix_i,
  yl_lab_if.source lab_o
);

  // ---- register file ----
  logic signed [31:0] x_from_u_q, x_from_v_q, z_from_u_q, z_from_v_q;
  logic signed [31:0] a_gain_q, b_gain_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_from_u_q <= '0;
      x_from_v_q <= '0;
      z_from_u_q <= '0;
      z_from_v_q <= '0;
      a_gain_q   <= '0;
      b_gain_q   <= '0;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_X_FROM_U: x_from_u_q <= $signed(cfg_i.data);
        REG_X_FROM_V: x_from_v_q <= $signed(cfg_i.data);
        REG_Z_FROM_U: z_from_u_q <= $signed(cfg_i.data);
        REG_Z_FROM_V: z_from_v_q <= $signed(cfg_i.data);
        REG_A_GAIN:   a_gain_q   <= $signed(cfg_i.data);
        REG_B_GAIN:   b_gain_q   <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  // ---- pipeline control: a stage loads when empty or draining ----
  logic [NUM_STAGES:1] v_q;
  logic [NUM_STAGES:1] en;
  logic [NUM_STAGES:1] eor_q;

  always_comb begin
    en[NUM_STAGES] = !v_q[NUM_STAGES] || lab_o.ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= pix_i.valid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // run marker rides along
  always_ff @(posedge clk_i) begin
    if (en[1]) eor_q[1] <= pix_i.end_of_run;
    for (int k = 2; k <= NUM_STAGES; k++) begin
      if (en[k]) eor_q[k] <= eor_q[k-1];
    end
  end

  assign pix_i.ready = en[1];

  // ---- stage 1: luma position, chroma products ----
  logic signed [16:0]       uc, vc;
  logic        [PY_W-2:0]   ys;
  logic        [PY_W-1:0]   ysum;
  logic        [TABLE_BITS-1:0] k0;
  logic        [16:0]       rem;
  logic        [TABLE_BITS:0] kq;
  logic        [PY_W-1:0]   py_d, py1_q;
  logic signed [48:0]       mxu, mxv, mzu, mzv;
  logic signed [47:0]       mxu_q, mxv_q, mzu_q, mzv_q;

  assign uc = $signed({1'b0, pix_i.chroma_u}) - 17'sd32768;
  assign vc = $signed({1'b0, pix_i.chroma_v}) - 17'sd32768;

  // py = round(y * N * 2^15 / 65535), split as y*N/2 plus a small quotient
  assign ys   = (PY_W-1)'(pix_i.luma) << (TABLE_BITS - 1);
  assign ysum = PY_W'(ys) + PY_W'(32767);
  assign k0   = ysum[PY_W-1:16];
  assign rem  = 17'(ysum[15:0]) + 17'(k0);
  assign kq   = (TABLE_BITS+1)'(k0) + {{TABLE_BITS{1'b0}}, (rem >= 17'd65535)};
  assign py_d = PY_W'(ys) + PY_W'(kq);

  assign mxu = uc * x_from_u_q;
  assign mxv = vc * x_from_v_q;
  assign mzu = uc * z_from_u_q;
  assign mzv = vc * z_from_v_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      py1_q <= py_d;
      mxu_q <= 48'(mxu);
      mxv_q <= 48'(mxv);
      mzu_q <= 48'(mzu);
      mzv_q <= 48'(mzv);
    end
  end

  // ---- stage 2: X and Z positions, segment and fraction ----
  logic signed [POS_W-1:0]  pyp, px, pz;
  logic [TABLE_BITS-1:0]    ix_q, iy_q, iz_q;
  logic [15:0]              fx_frac_q, fy_frac_q, fz_frac_q;

  assign pyp = POS_W'($signed({1'b0, py1_q}));
  assign px  = pyp + POS_W'(rnd_q16(mxu_q)) + POS_W'(rnd_q16(mxv_q));
  assign pz  = pyp + POS_W'(rnd_q16(mzu_q)) + POS_W'(rnd_q16(mzv_q));

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ix_q      <= px[16+TABLE_BITS-1:16];
      iy_q      <= pyp[16+TABLE_BITS-1:16];
      iz_q      <= pz[16+TABLE_BITS-1:16];
      fx_frac_q <= px[15:0];
      fy_frac_q <= pyp[15:0];
      fz_frac_q <= pz[15:0];
    end
  end

  // ---- stages 3..7: spline evaluation per channel ----
  spl_en_t                  spl_en;
  logic signed [COEF_W-1:0] fx, fy, fz;

  assign spl_en.ld_rom  = en[3];
  assign spl_en.ld_mul1 = en[4];
  assign spl_en.ld_mul2 = en[5];
  assign spl_en.ld_mul3 = en[6];
  assign spl_en.ld_sum  = en[7];

  yl_spline_eval u_spl_x (
    .clk_i (clk_i), .en_i (spl_en), .idx_i (ix_q), .frac_i (fx_frac_q), .f_o (fx)
  );
  yl_spline_eval u_spl_y (
    .clk_i (clk_i), .en_i (spl_en), .idx_i (iy_q), .frac_i (fy_frac_q), .f_o (fy)
  );
  yl_spline_eval u_spl_z (
    .clk_i (clk_i), .en_i (spl_en), .idx_i (iz_q), .frac_i (fz_frac_q), .f_o (fz)
  );

  // ---- stages 8..11: L, a, b ----
  post_en_t post_en;

  assign post_en.ld_diff  = en[8];
  assign post_en.ld_prod  = en[9];
  assign post_en.ld_scale = en[10];
  assign post_en.ld_out   = en[11];

  yl_lab_math u_lab (
    .clk_i       (clk_i),
    .en_i        (post_en),
    .fx_i        (fx),
    .fy_i        (fy),
    .fz_i        (fz),
    .a_gain_i    (a_gain_q),
    .b_gain_i    (b_gain_q),
    .lightness_o (lab_o.lightness),
    .a_channel_o (lab_o.a_channel),
    .b_channel_o (lab_o.b_channel)
  );

  assign lab_o.valid          = v_q[NUM_STAGES];
  assign lab_o.end_of_run_out = eor_q[NUM_STAGES];

endmodule

FILE: sv/yl_checker.sv
// ----------------------------------------------------------------------------
// yl_checker
// Port-level checks of the converter: occupancy bound, no invented beats,
// input never blocked while the output is empty, stalled output holds.
// ----------------------------------------------------------------------------
module yl_checker import yl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_l_i,
  input logic [15:0] out_a_i,
  input logic [15:0] out_b_i,
  input logic        out_eor_i
);

  localparam int CNT_W = $clog2(NUM_STAGES + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             inc, dec;

  // pixels in flight
  assign inc   = in_valid_i && in_ready_i;
  assign dec   = out_valid_i && out_ready_i;
  assign cnt_d = cnt_q + CNT_W'(inc) - CNT_W'(dec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_STAGES))
    else $error("more pixels in flight than pipeline stages");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("output beat without a pending input beat");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked while output register is empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({out_l_i, out_a_i, out_b_i, out_eor_i}))
    else $error("stalled output beat changed");

endmodule

bind yuv_to_lab_spline_converter yl_checker u_yl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (lab_o.valid),
  .out_ready_i (lab_o.ready),
  .out_l_i     (lab_o.lightness),
  .out_a_i     (lab_o.a_channel),
  .out_b_i     (lab_o.b_channel),
  .out_eor_i   (lab_o.end_of_run_out)
);
